// ===== src/fccw_pkg.sv =====
// Shared types and constants of the FAT12 cluster chain walker.
package fccw_pkg;

  // Allocation table size in bytes and its address width
  localparam int TABLE_BYTES = 8192;
  localparam int TABLE_AW    = $clog2(TABLE_BYTES);

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QUEUE_PW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

  // FAT12 entry constants
  localparam logic [11:0] ENTRY_MASK         = 12'hFFF;
  localparam logic [11:0] CHAIN_END          = 12'hFF8;
  localparam logic [11:0] FIRST_DATA_CLUSTER = 12'h002;

  // Input item kinds
  localparam logic [1:0] KIND_WRITE   = 2'd0;
  localparam logic [1:0] KIND_START   = 2'd1;
  localparam logic [1:0] KIND_ADVANCE = 2'd2;

  // Configuration register indexes
  localparam int         CFG_IW            = 1;
  localparam logic [0:0] REG_DATA_BASE     = 1'b0;
  localparam logic [0:0] REG_CLUSTER_BYTES = 1'b1;
  localparam logic [16:0] CLUSTER_BYTES_RST = 17'd512;

  // Operation carried by a queued command
  typedef enum logic [1:0] {
    OP_WRITE   = 2'd0,
    OP_START   = 2'd1,
    OP_ADVANCE = 2'd2
  } op_t;

  // Walk status codes on the result
  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_END     = 2'd1,
    ST_NO_WALK = 2'd2
  } status_t;

  // Classified command
  typedef struct packed {
    op_t                 op;
    logic [TABLE_AW-1:0] offset;
    logic [7:0]          data;
    logic [11:0]         cluster;
    logic [31:0]         count;
  } cmd_t;

  // Queue status seen by front and back
  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

  // Configuration register values
  typedef struct packed {
    logic [31:0] data_base;
    logic [16:0] cluster_bytes;
  } cfg_t;

endpackage

// ===== src/fccw_ram.sv =====
// Generic single write port, single read port RAM with registered read.
module fccw_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ===== src/fccw_front.sv =====
// Front end: accepts input items and classifies them into queued commands.
module fccw_front import fccw_pkg::*; (
  input  logic        start,
  input  q_stat_t     q_stat,
  input  logic [1:0]  kind,
  input  logic [12:0] table_offset,
  input  logic [7:0]  table_byte,
  input  logic [11:0] start_cluster,
  input  logic [31:0] byte_count,
  output logic        push,
  output cmd_t        cmd
);

  logic accept;
  logic in_table;

  assign accept   = start && !q_stat.full;
  assign in_table = (32'(table_offset) < 32'(TABLE_BYTES));

  // Kind decode; writes beyond the table and unknown kinds are dropped
  always_comb begin
    // Payload common to every command
    cmd.offset  = TABLE_AW'(table_offset);
    cmd.data    = table_byte;
    cmd.cluster = start_cluster;
    cmd.count   = byte_count;
    unique case (kind)
      KIND_WRITE: begin
        cmd.op = OP_WRITE;
        push   = accept && in_table;
      end
      KIND_START: begin
        cmd.op = OP_START;
        push   = accept;
      end
      KIND_ADVANCE: begin
        cmd.op = OP_ADVANCE;
        push   = accept;
      end
      default: begin
        cmd.op = OP_WRITE;
        push   = 1'b0;
      end
    endcase
  end

endmodule

// ===== src/fccw_queue.sv =====
// Short command FIFO between the front and back ends.
module fccw_queue import fccw_pkg::*; (
  input  logic    clk,
  input  logic    rst,
  input  logic    push,
  input  cmd_t    push_cmd,
  input  logic    pop,
  output cmd_t    pop_cmd,
  output q_stat_t q_stat
);

  cmd_t                slots [QUEUE_DEPTH];
  logic [QUEUE_PW-1:0] wr_ptr;
  logic [QUEUE_PW-1:0] rd_ptr;
  logic [QUEUE_CW-1:0] count;

  assign pop_cmd      = slots[rd_ptr];
  assign q_stat.full  = (count == QUEUE_CW'(QUEUE_DEPTH));
  assign q_stat.empty = (count == '0);

  function automatic logic [QUEUE_PW-1:0] ptr_inc(input logic [QUEUE_PW-1:0] p);
    ptr_inc = (p == QUEUE_PW'(QUEUE_DEPTH - 1)) ? '0 : p + 1'b1;
  endfunction

  // Slot storage
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= push_cmd;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= ptr_inc(wr_ptr);
      end
      if (pop) begin
        rd_ptr <= ptr_inc(rd_ptr);
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== src/fccw_back.sv =====
// Back end: executes commands, holds the table and walk state, emits descriptors.
module fccw_back import fccw_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  cfg_t        cfg,
  input  cmd_t        cmd,
  input  q_stat_t     q_stat,
  output logic        pop,
  output logic        done,
  output logic [31:0] chunk_addr,
  output logic [16:0] chunk_len,
  output logic        is_last,
  output logic [1:0]  walk_status
);

  typedef enum logic [3:0] {
    S_IDLE = 4'b0001,
    S_ADDR = 4'b0010,
    S_RD0  = 4'b0100,
    S_RD1  = 4'b1000
  } state_t;

  state_t      state;
  logic [11:0] current_cluster;
  logic [31:0] bytes_left;
  logic        walk_active;
  logic [28:0] prod;
  logic [16:0] len;
  logic [7:0]  lo_byte;

  logic                ram_we;
  logic [TABLE_AW-1:0] ram_raddr;
  logic [7:0]          ram_rdata;
  logic [12:0]         entry_offset;
  logic                cluster_ok;
  logic [16:0]         take_len;
  logic                len_is_rest;
  logic [15:0]         entry_word;
  logic [11:0]         cluster_next;

  // Table entry byte offset: cluster * 1.5
  assign entry_offset = {1'b0, current_cluster} + {2'b00, current_cluster[11:1]};
  assign ram_raddr    = (state == S_RD0) ? TABLE_AW'(entry_offset + 13'd1)
                                         : TABLE_AW'(entry_offset);

  assign pop    = (state == S_IDLE) && !q_stat.empty;
  assign ram_we = pop && (cmd.op == OP_WRITE);

  fccw_ram #(
    .WIDTH (8),
    .DEPTH (TABLE_BYTES)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (cmd.offset),
    .wdata (cmd.data),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Cluster range check and length clamp
  assign cluster_ok  = (current_cluster >= FIRST_DATA_CLUSTER) &&
                       (current_cluster < CHAIN_END);
  assign take_len    = (bytes_left < {15'd0, cfg.cluster_bytes}) ? bytes_left[16:0]
                                                                 : cfg.cluster_bytes;
  assign len_is_rest = (bytes_left == {15'd0, len});

  // Next cluster from the little endian entry word
  assign entry_word   = {ram_rdata, lo_byte};
  assign cluster_next = current_cluster[0] ? (entry_word[15:4] & ENTRY_MASK)
                                           : (entry_word[11:0] & ENTRY_MASK);

  // Sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state           <= S_IDLE;
      current_cluster <= '0;
      bytes_left      <= '0;
      walk_active     <= 1'b0;
      done            <= 1'b0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_IDLE: begin
          if (pop) begin
            case (cmd.op)
              OP_START: begin
                current_cluster <= cmd.cluster;
                bytes_left      <= cmd.count;
                walk_active     <= 1'b1;
              end
              OP_ADVANCE: begin
                if (!walk_active) begin
                  done        <= 1'b1;
                  chunk_addr  <= '0;
                  chunk_len   <= '0;
                  is_last     <= 1'b0;
                  walk_status <= ST_NO_WALK;
                end else if (!cluster_ok) begin
                  done        <= 1'b1;
                  chunk_addr  <= '0;
                  chunk_len   <= '0;
                  is_last     <= 1'b1;
                  walk_status <= ST_END;
                  walk_active <= 1'b0;
                end else begin
                  prod  <= 29'(current_cluster - FIRST_DATA_CLUSTER) *
                           29'(cfg.cluster_bytes);
                  len   <= take_len;
                  state <= S_ADDR;
                end
              end
              default: begin
              end
            endcase
          end
        end
        S_ADDR: begin
          done        <= 1'b1;
          chunk_addr  <= cfg.data_base + 32'(prod);
          chunk_len   <= len;
          is_last     <= len_is_rest;
          walk_status <= ST_OK;
          bytes_left  <= bytes_left - {15'd0, len};
          if (len_is_rest) begin
            walk_active <= 1'b0;
            state       <= S_IDLE;
          end else begin
            state <= S_RD0;
          end
        end
        S_RD0: begin
          lo_byte <= ram_rdata;
          state   <= S_RD1;
        end
        S_RD1: begin
          current_cluster <= cluster_next;
          state           <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

endmodule

// ===== src/fat12_cluster_chain_walker.sv =====
// Top level of the FAT12 cluster chain walker.
// An item is taken when start is high and busy is low; busy is high while the
// two-entry command queue is full. A taken item is registered in the queue
// before the back end can pop it. In the back end a table write or a start is
// done as it is popped, and so is an advance that ends the walk or finds no walk.
// An advance that emits the last descriptor of a file first does the 12x17
// offset multiply and then emits the descriptor. Any other descriptor needs the
// multiply, then the emit step that also addresses the first entry byte, then
// the reads of the two table bytes through the single read port of the table RAM.
// Each result is shown for exactly one cycle with done high and cannot be
// held off by the receiver. Configuration writes land at once and must only be
// made while no item is in flight.
module fat12_cluster_chain_walker import fccw_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              start,
  output logic              busy,
  input  logic [1:0]        kind,
  input  logic [12:0]       table_offset,
  input  logic [7:0]        table_byte,
  input  logic [11:0]       start_cluster,
  input  logic [31:0]       byte_count,
  input  logic              cfg_we,
  input  logic [CFG_IW-1:0] cfg_index,
  input  logic [31:0]       cfg_data,
  output logic              done,
  output logic [31:0]       chunk_addr,
  output logic [16:0]       chunk_len,
  output logic              is_last,
  output logic [1:0]        walk_status
);

  cfg_t    cfg;
  q_stat_t q_stat;
  cmd_t    push_cmd;
  cmd_t    pop_cmd;
  logic    push;
  logic    pop;

  assign busy = q_stat.full;

  // Configuration registers
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.data_base     <= '0;
      cfg.cluster_bytes <= CLUSTER_BYTES_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_DATA_BASE:     cfg.data_base     <= cfg_data;
        REG_CLUSTER_BYTES: cfg.cluster_bytes <= cfg_data[16:0];
        default: begin
        end
      endcase
    end
  end

  fccw_front u_front (
    .start         (start),
    .q_stat        (q_stat),
    .kind          (kind),
    .table_offset  (table_offset),
    .table_byte    (table_byte),
    .start_cluster (start_cluster),
    .byte_count    (byte_count),
    .push          (push),
    .cmd           (push_cmd)
  );

  fccw_queue u_queue (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .push_cmd (push_cmd),
    .pop      (pop),
    .pop_cmd  (pop_cmd),
    .q_stat   (q_stat)
  );

  fccw_back u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd         (pop_cmd),
    .q_stat      (q_stat),
    .pop         (pop),
    .done        (done),
    .chunk_addr  (chunk_addr),
    .chunk_len   (chunk_len),
    .is_last     (is_last),
    .walk_status (walk_status)
  );

endmodule

// ===== src/fccw_checker.sv =====
// Port level checks of the FAT12 cluster chain walker, bound to the top level.
module fccw_checker import fccw_pkg::*; (
  input logic        clk,
  input logic        rst,
  input logic        busy,
  input logic        done,
  input logic [31:0] chunk_addr,
  input logic [16:0] chunk_len,
  input logic        is_last,
  input logic [1:0]  walk_status
);

  // Advance with no walk gives an all-zero descriptor
  a_no_walk_zero: assert property (@(posedge clk) disable iff (rst)
    (done && walk_status == ST_NO_WALK) |->
      (chunk_addr == '0 && chunk_len == '0 && !is_last))
    else $error("no-walk result carries a descriptor");

  // Chain end always closes the walk with an empty descriptor
  a_end_last: assert property (@(posedge clk) disable iff (rst)
    (done && walk_status == ST_END) |-> (is_last && chunk_len == '0))
    else $error("chain end result not marked last or not empty");

  // Queue is empty right after reset
  a_reset_not_busy: assert property (@(posedge clk)
    $past(rst) |-> !busy)
    else $error("busy right after reset");

  // No result comes out of reset
  a_reset_no_done: assert property (@(posedge clk)
    rst |=> !done)
    else $error("result strobe right after reset");

endmodule

bind fat12_cluster_chain_walker fccw_checker u_checker (
  .clk         (clk),
  .rst         (rst),
  .busy        (busy),
  .done        (done),
  .chunk_addr  (chunk_addr),
  .chunk_len   (chunk_len),
  .is_last     (is_last),
  .walk_status (walk_status)
);
